[src/spq_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared types and codes for the sorted priority queue unit.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Default number of entries held by the queue.
  localparam int SPQ_DEPTH = 16;

  // Operation codes of a request.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // One stored entry.
  typedef struct packed {
    logic [15:0] code;
    logic [7:0]  priority_val;
  } entry_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_LAST,
    S_DEQ,
    S_RESULT
  } state_t;

endpackage

[src/spq_if.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue channels
// Request and result channels with a valid/ready handshake.
// ----------------------------------------------------------------------------

// Request channel: one insert or remove.
interface spq_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] item_code;
  logic [7:0]  item_priority;

  modport source (output valid, output op, output item_code, output item_priority,
                  input ready);
  modport sink (input valid, input op, input item_code, input item_priority,
                output ready);
endinterface

// Result channel: one result per request.
interface spq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] out_code;
  logic [7:0]  out_priority;
  logic [4:0]  occupancy;

  modport source (output valid, output status, output out_code, output out_priority,
                  output occupancy, input ready);
  modport sink (input valid, input status, input out_code, input out_priority,
                input occupancy, output ready);
endinterface

[src/spq_mem.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue entry memory
// Simple dual-port entry store: one write and one registered read a cycle.
// ----------------------------------------------------------------------------
module spq_mem
  import spq_pkg::*;
#(
  parameter int DEPTH = SPQ_DEPTH,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/sorted_priority_queue_unit.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue unit
// Entries kept in ascending priority order in a circular entry memory.
// ----------------------------------------------------------------------------
// The queue holds up to DEPTH entries in a ring in one memory with one write
// and one read port. A request is taken only when the controller is idle and
// its result follows through an output register, so a new request may enter
// while the previous result still waits. A rejected insert, a remove on an
// empty queue and an insert into an empty queue go straight to the result
// state; a remove passes through a dequeue state; any other insert moves each
// stored entry of higher priority up one slot, one at a time, through the
// single memory read and write ports. Reset needs no clearing pass.
module sorted_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int DEPTH = SPQ_DEPTH
) (
  input  logic   clk,
  input  logic   rst_n,
  spq_in_if.sink   in_chan,
  spq_out_if.source out_chan
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  // Ring pointer helpers.
  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
  endfunction

  state_t        state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] hole_ph_r, hole_ph_nxt;
  logic [CW-1:0] hole_lg_r, hole_lg_nxt;
  entry_t        new_r, new_nxt;
  logic [1:0]    res_status_r, res_status_nxt;
  entry_t        res_entry_r, res_entry_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  entry_t        out_entry_r, out_entry_nxt;
  logic [4:0]    out_occ_r, out_occ_nxt;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_rdata;

  logic          in_fire;
  logic          out_free;
  logic          full;
  logic          empty;
  logic          shift_up;
  entry_t        req_entry;

  // Requests are taken only while the controller is idle.
  assign in_chan.ready = (state_r == S_IDLE);

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;
  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  // A stored entry of strictly higher priority value moves up past the new one.
  assign shift_up = (mem_rdata.priority_val > new_r.priority_val);

  assign req_entry.code         = in_chan.item_code;
  assign req_entry.priority_val = in_chan.item_priority;

  // Entry memory.
  spq_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_chan.op == OP_INSERT) begin
            state_nxt = (full || empty) ? S_RESULT : S_INS_CMP;
          end else begin
            state_nxt = empty ? S_RESULT : S_DEQ;
          end
        end
      end
      S_INS_CMP: begin
        if (!shift_up) begin
          state_nxt = S_RESULT;
        end else if (hole_lg_r == CW'(1)) begin
          state_nxt = S_INS_LAST;
        end
      end
      S_INS_LAST: state_nxt = S_RESULT;
      S_DEQ:      state_nxt = S_RESULT;
      S_RESULT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Memory accesses and datapath updates.
  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    hole_ph_nxt    = hole_ph_r;
    hole_lg_nxt    = hole_lg_r;
    new_nxt        = new_r;
    res_status_nxt = res_status_r;
    res_entry_nxt  = res_entry_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_status_nxt = out_status_r;
    out_entry_nxt  = out_entry_r;
    out_occ_nxt    = out_occ_r;
    mem_we         = 1'b0;
    mem_waddr      = hole_ph_r;
    mem_wdata      = new_r;
    mem_re         = 1'b0;
    mem_raddr      = ptr_dec(hole_ph_r);
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          new_nxt        = req_entry;
          res_status_nxt = ST_DONE;
          res_entry_nxt  = '0;
          if (in_chan.op == OP_INSERT) begin
            if (full) begin
              res_status_nxt = ST_FULL;
            end else if (empty) begin
              // First entry goes straight into the tail slot.
              mem_we    = 1'b1;
              mem_waddr = tail_r;
              mem_wdata = req_entry;
              tail_nxt  = ptr_inc(tail_r);
              count_nxt = count_r + CW'(1);
            end else begin
              // Open the hole at the tail and fetch the entry below it.
              mem_re      = 1'b1;
              mem_raddr   = ptr_dec(tail_r);
              hole_ph_nxt = tail_r;
              hole_lg_nxt = count_r;
            end
          end else begin
            if (empty) begin
              res_status_nxt = ST_EMPTY;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = head_r;
            end
          end
        end
      end
      S_INS_CMP: begin
        mem_we = 1'b1;
        if (shift_up) begin
          // Move the fetched entry into the hole and look one slot lower.
          mem_wdata   = mem_rdata;
          hole_ph_nxt = ptr_dec(hole_ph_r);
          hole_lg_nxt = hole_lg_r - CW'(1);
          if (hole_lg_r != CW'(1)) begin
            mem_re    = 1'b1;
            mem_raddr = ptr_dec(ptr_dec(hole_ph_r));
          end
        end else begin
          tail_nxt  = ptr_inc(tail_r);
          count_nxt = count_r + CW'(1);
        end
      end
      S_INS_LAST: begin
        // The hole has reached the head: the new entry becomes the head.
        mem_we    = 1'b1;
        head_nxt  = hole_ph_r;
        tail_nxt  = ptr_inc(tail_r);
        count_nxt = count_r + CW'(1);
      end
      S_DEQ: begin
        res_entry_nxt = mem_rdata;
        head_nxt      = ptr_inc(head_r);
        count_nxt     = count_r - CW'(1);
      end
      S_RESULT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_entry_nxt  = res_entry_r;
          out_occ_nxt    = 5'(count_r);
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    hole_ph_r    <= hole_ph_nxt;
    hole_lg_r    <= hole_lg_nxt;
    new_r        <= new_nxt;
    res_status_r <= res_status_nxt;
    res_entry_r  <= res_entry_nxt;
    out_status_r <= out_status_nxt;
    out_entry_r  <= out_entry_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  // Result channel.
  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = out_status_r;
  assign out_chan.out_code     = out_entry_r.code;
  assign out_chan.out_priority = out_entry_r.priority_val;
  assign out_chan.occupancy    = out_occ_r;

endmodule

[tb/sv/sorted_priority_queue_unit_tb.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue unit testbench
// Drives insert and remove requests with random gaps, keeps its own sorted
// copy of the queue to predict each result, and checks every result field
// against that prediction while the result side stalls at random.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit_tb
  import spq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // One request waiting to be offered, with the idle cycles that precede it.
  typedef struct {
    logic        op;
    logic [15:0] code;
    logic [7:0]  prio;
    int unsigned gap;
    bit          wait_empty;
  } queue_req_t;

  // One predicted result.
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] code;
    logic [7:0]  prio;
    logic [4:0]  occupancy;
  } queue_result_t;

  // Request mix of one stretch of the random part.
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  localparam int RANDOM_REQS  = 1900;
  localparam int LONG_HOLD    = 90;
  localparam int TIMEOUT_NS   = 5_000_000;
  localparam int MAX_PRINTS   = 100;

  logic clk;
  logic rst_n;

  spq_in_if  in_chan ();
  spq_out_if out_chan ();

  sorted_priority_queue_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Requests still to be offered, and results predicted but not yet seen.
  queue_req_t    pending_reqs[$];
  queue_result_t awaited_results[$];

  // Shadow copy of the queue contents, head at index 0.
  logic [15:0] shadow_codes [SPQ_DEPTH];
  logic [7:0]  shadow_prios [SPQ_DEPTH];
  int          shadow_count;

  int  fail_count;
  bit  send_calm;
  bit  req_loaded;

  // Clock generation.
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Prints one line per mismatch, up to a limit, and counts them all.
  task automatic report_mismatch(input string what, input longint exp_v, input longint got_v);
    fail_count++;
    if (fail_count <= MAX_PRINTS)
      $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, exp_v, got_v);
  endtask

  // Applies one accepted request to the shadow queue and records its result.
  task automatic predict_queue_result(input logic op, input logic [15:0] code,
                                      input logic [7:0] prio);
    queue_result_t r;
    int pos;
    int k;
    r = '0;
    if (op == OP_INSERT) begin
      if (shadow_count >= SPQ_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // The new entry goes after every entry of lower or equal priority.
        pos = 0;
        while (pos < shadow_count && shadow_prios[pos] <= prio) pos++;
        for (k = shadow_count; k > pos; k--) begin
          shadow_codes[k] = shadow_codes[k-1];
          shadow_prios[k] = shadow_prios[k-1];
        end
        shadow_codes[pos] = code;
        shadow_prios[pos] = prio;
        shadow_count++;
        r.status = ST_DONE;
      end
    end else if (shadow_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.status = ST_DONE;
      r.code   = shadow_codes[0];
      r.prio   = shadow_prios[0];
      for (k = 1; k < shadow_count; k++) begin
        shadow_codes[k-1] = shadow_codes[k];
        shadow_prios[k-1] = shadow_prios[k];
      end
      shadow_count--;
    end
    r.occupancy = 5'(shadow_count);
    awaited_results.push_back(r);
  endtask

  // Queues one request; the gap is drawn here, with calm stretches of none.
  task automatic add_req(input logic op, input logic [15:0] code, input logic [7:0] prio,
                         input bit wait_empty);
    queue_req_t q;
    if ($urandom_range(0, 49) == 0) send_calm = !send_calm;
    q.op         = op;
    q.code       = code;
    q.prio       = prio;
    q.gap        = send_calm ? 0 : $urandom_range(0, 7);
    q.wait_empty = wait_empty;
    pending_reqs.push_back(q);
  endtask

  // Stimulus: a directed opening, then stretches of biased random requests.
  initial begin
    mix_t        mix;
    int          stretch;
    int          prio_kind;
    int          n;
    int          j;
    logic        op;
    logic [7:0]  prio;

    fail_count   = 0;
    shadow_count = 0;
    send_calm    = 1'b0;
    req_loaded   = 1'b0;

    // Every input known from the first instant.
    rst_n                 = 1'b0;
    in_chan.valid         = 1'b0;
    in_chan.op            = OP_INSERT;
    in_chan.item_code     = '0;
    in_chan.item_priority = '0;
    out_chan.ready        = 1'b0;

    // Remove from an empty queue, then the field extremes.
    add_req(OP_REMOVE, 16'h0000, 8'h00, 1'b0);
    add_req(OP_INSERT, 16'h0000, 8'h00, 1'b0);
    add_req(OP_INSERT, 16'hFFFF, 8'hFF, 1'b0);
    add_req(OP_REMOVE, 16'hFFFF, 8'hFF, 1'b0);
    add_req(OP_REMOVE, 16'h0000, 8'h00, 1'b0);

    // A new head, equal priorities kept in arrival order, and both ends.
    add_req(OP_INSERT, 16'h1111, 8'd100, 1'b0);
    add_req(OP_INSERT, 16'h2222, 8'd50, 1'b0);
    add_req(OP_INSERT, 16'h3333, 8'd100, 1'b0);
    add_req(OP_INSERT, 16'h4444, 8'd255, 1'b0);
    add_req(OP_INSERT, 16'h5555, 8'd0, 1'b0);

    // Fill to the brim, then one insert too many.
    for (j = 0; j < SPQ_DEPTH - 5; j++)
      add_req(OP_INSERT, 16'($urandom), 8'($urandom), 1'b0);
    add_req(OP_INSERT, 16'hA5A5, 8'h5A, 1'b0);
    add_req(OP_REMOVE, 16'($urandom), 8'($urandom), 1'b0);
    add_req(OP_REMOVE, 16'($urandom), 8'($urandom), 1'b0);
    add_req(OP_REMOVE, 16'($urandom), 8'($urandom), 1'b1);

    // Random stretches that fill, drain or balance the queue.
    n = 0;
    while (n < RANDOM_REQS) begin
      mix       = mix_t'($urandom_range(0, 2));
      stretch   = $urandom_range(10, 60);
      prio_kind = $urandom_range(0, 3);
      for (j = 0; j < stretch; j++) begin
        case (mix)
          MIX_FILL:  op = ($urandom_range(0, 9) < 2) ? OP_REMOVE : OP_INSERT;
          MIX_DRAIN: op = ($urandom_range(0, 9) < 2) ? OP_INSERT : OP_REMOVE;
          default:   op = $urandom_range(0, 1) ? OP_REMOVE : OP_INSERT;
        endcase
        case (prio_kind)
          0:       prio = 8'($urandom_range(0, 255));
          1:       prio = 8'($urandom_range(0, 3));
          2:       prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          default: prio = 8'($urandom_range(120, 135));
        endcase
        n++;
        // Now and then the sender waits for the queue of results to run dry.
        add_req(op, 16'($urandom), prio, (n % 450) == 0);
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Request driver.
  always @(posedge clk) begin
    queue_req_t cur;
    int unsigned gap_left;
    logic        accepted;
    logic        next_valid;
    if (!rst_n) begin
      in_chan.valid         <= 1'b0;
      in_chan.op            <= OP_INSERT;
      in_chan.item_code     <= '0;
      in_chan.item_priority <= '0;
    end else begin
      accepted = in_chan.valid && in_chan.ready;
      if (accepted) begin
        predict_queue_result(cur.op, cur.code, cur.prio);
        req_loaded = 1'b0;
      end
      if (!req_loaded && pending_reqs.size() != 0) begin
        cur        = pending_reqs.pop_front();
        gap_left   = cur.gap;
        req_loaded = 1'b1;
      end
      next_valid = 1'b0;
      if (req_loaded) begin
        if (in_chan.valid && !accepted)
          next_valid = 1'b1;
        else if (gap_left != 0)
          gap_left--;
        else if (!(cur.wait_empty && awaited_results.size() != 0))
          next_valid = 1'b1;
      end
      in_chan.valid <= next_valid;
      // While idle the payload carries junk that the block must ignore.
      if (next_valid) begin
        in_chan.op            <= cur.op;
        in_chan.item_code     <= cur.code;
        in_chan.item_priority <= cur.prio;
      end else begin
        in_chan.op            <= 1'($urandom);
        in_chan.item_code     <= 16'($urandom);
        in_chan.item_priority <= 8'($urandom);
      end
    end
  end

  // Result monitor: checks each result and stalls at random, with long holds.
  always @(posedge clk) begin
    queue_result_t exp_r;
    int          results_seen;
    int unsigned recv_wait;
    int unsigned hold_left;
    bit          recv_calm;
    logic        next_ready;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      results_seen = 0;
      recv_wait    = 0;
      hold_left    = 0;
      recv_calm    = 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          report_mismatch("result with no request", -1, out_chan.status);
        end else begin
          exp_r = awaited_results.pop_front();
          if (out_chan.status !== exp_r.status)
            report_mismatch("status", exp_r.status, out_chan.status);
          if (out_chan.out_code !== exp_r.code)
            report_mismatch("out_code", exp_r.code, out_chan.out_code);
          if (out_chan.out_priority !== exp_r.prio)
            report_mismatch("out_priority", exp_r.prio, out_chan.out_priority);
          if (out_chan.occupancy !== exp_r.occupancy)
            report_mismatch("occupancy", exp_r.occupancy, out_chan.occupancy);
        end
        if ($urandom_range(0, 63) == 0) recv_calm = !recv_calm;
        recv_wait = recv_calm ? 0 : $urandom_range(0, 7);
        // A long hold lets the block back up and stall its request side.
        if ((results_seen % 800) == 300) hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else if (recv_wait != 0) begin
        recv_wait--;
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      out_chan.ready <= next_ready;
    end
  end

  // End of run: all requests taken and all results seen, then a short drain.
  initial begin
    @(posedge rst_n);
    while (pending_reqs.size() != 0 || req_loaded || awaited_results.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
    if (awaited_results.size() != 0)
      report_mismatch("results still awaited", 0, awaited_results.size());
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // Watchdog.
  initial begin
    #TIMEOUT_NS;
    $display("TEST FAILED");
    $finish;
  end

endmodule

[files.f]
src/spq_pkg.sv
src/spq_if.sv
src/spq_mem.sv
src/sorted_priority_queue_unit.sv
tb/sv/sorted_priority_queue_unit_tb.sv
